FILE: rtl/three_nearest_point_search_defines.svh
// Assertion macros used by the three-nearest-point search top module.
`ifndef THREE_NEAREST_POINT_SEARCH_DEFINES_SVH
`define THREE_NEAREST_POINT_SEARCH_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define TNPS_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tnps invariant violated");

// A condition that must hold in the cycle after a trigger.
`define TNPS_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("tnps sequence check failed");

`endif

FILE: rtl/tnps_pkg.sv
// Types, constants and helper functions of the three-nearest-point search.
package tnps_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int INDEX_BITS_DEF = 16;
  localparam int SLOTS          = 3;
  localparam int RANK_W         = 2;
  localparam logic [RANK_W-1:0] FIRST_RANK = 2'd0;
  localparam logic [RANK_W-1:0] LAST_RANK  = 2'd2;
  localparam int SNAP_DEPTH     = 2;
  localparam int DIST_SAT_BITS  = 64;

  typedef enum logic {
    CMD_QUERY = 1'b0,
    CMD_CAND  = 1'b1
  } cmd_t;

  // Control that travels alongside each item in the distance pipeline.
  typedef struct packed {
    logic vld;
    cmd_t cmd;
    logic fin;
  } item_ctl_t;

  // Broadcast from the top level to every slot cell.
  typedef struct packed {
    logic clear;
    logic write;
  } cell_ctl_t;

  // Width of a squared distance: exact sum of three squares, saturated at 64 bits.
  function automatic int dist_width(input int coord_bits);
    int sum_w;
    sum_w = 2 * (coord_bits + 1) + 2;
    return (sum_w > DIST_SAT_BITS) ? DIST_SAT_BITS : sum_w;
  endfunction

endpackage

FILE: rtl/tnps_if.sv
// Request and result channel interfaces of the three-nearest-point search.
interface tnps_in_if #(
  parameter int IDX_W = tnps_pkg::INDEX_BITS_DEF,
  parameter int CRD_W = tnps_pkg::COORD_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  tnps_pkg::cmd_t          cmd;
  logic [IDX_W-1:0]        vertex_index;
  logic signed [CRD_W-1:0] coord_x;
  logic signed [CRD_W-1:0] coord_y;
  logic signed [CRD_W-1:0] coord_z;
  logic                    final_candidate;

  modport source (
    output valid, cmd, vertex_index, coord_x, coord_y, coord_z, final_candidate,
    input  ready
  );
  modport sink (
    input  valid, cmd, vertex_index, coord_x, coord_y, coord_z, final_candidate,
    output ready
  );
endinterface

interface tnps_out_if #(
  parameter int IDX_W = tnps_pkg::INDEX_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic [IDX_W-1:0]            query_vertex;
  logic [tnps_pkg::RANK_W-1:0] rank;
  logic [IDX_W-1:0]            neighbor_vertex;
  logic                        found;
  logic                        run_end;

  modport source (
    output valid, query_vertex, rank, neighbor_vertex, found, run_end,
    input  ready
  );
  modport sink (
    input  valid, query_vertex, rank, neighbor_vertex, found, run_end,
    output ready
  );
endinterface

FILE: rtl/three_nearest_point_search.sv
// Three-nearest-point search: usage notes
// in_ch carries requests. A query request (cmd 0) sets the query point and index and
// empties the ranked list; a candidate request (cmd 1) measures its squared distance to
// the query point and is inserted into the sorted three-slot list, unless its index is
// already held. A candidate with final_candidate set also produces three results on
// out_ch, ranks 0, 1 and 2, the last with run_end set; empty slots report found 0.
// One request is taken per clock cycle while in_ch.ready is high. The distance pipeline
// is four registers deep (input, differences, squares, sum) and the slot row updates on
// the following edge; the rank 0 result then goes out first and the other ranks follow
// one per cycle while out_ch.ready is high.
// Each final candidate sends three results through the result port; two list snapshots
// are buffered, and in_ch.ready falls only when a final candidate reaches the slot row
// with both buffers full. A stalled receiver therefore holds up requests after at most
// two pending result runs, and candidates without a final mark keep flowing meanwhile.
// Reset (rst_n low at a clock edge) sets the query point and index to zero, empties
// the list and drops any buffered results.
`include "three_nearest_point_search_defines.svh"

module three_nearest_point_search #(
  parameter int COORD_BITS = tnps_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = tnps_pkg::INDEX_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tnps_in_if.sink    in_ch,
  tnps_out_if.source out_ch
);

  localparam int DIST_W = tnps_pkg::dist_width(COORD_BITS);
  localparam int SLOTS  = tnps_pkg::SLOTS;

  logic                      en;
  tnps_pkg::item_ctl_t       s4_ctl;
  logic [INDEX_BITS-1:0]     s4_idx;
  logic [DIST_W-1:0]         s4_dist;
  tnps_pkg::cell_ctl_t       cell_ctl;
  logic                      is_query, is_cand, dup, cap, full;
  logic [INDEX_BITS-1:0]     query_id_r;

  logic [SLOTS-1:0]                  c_take, c_hit, c_vld, c_vld_nxt;
  logic [SLOTS-1:0][INDEX_BITS-1:0]  c_id_nxt;
  logic [DIST_W-1:0]                 c_dist [SLOTS];
  logic [INDEX_BITS-1:0]             c_id   [SLOTS];
  logic [SLOTS-1:0]                  p_take, p_vld;
  logic [DIST_W-1:0]                 p_dist [SLOTS];
  logic [INDEX_BITS-1:0]             p_id   [SLOTS];

  assign is_query = s4_ctl.vld && (s4_ctl.cmd == tnps_pkg::CMD_QUERY);
  assign is_cand  = s4_ctl.vld && (s4_ctl.cmd == tnps_pkg::CMD_CAND);

  // The whole pipeline holds while a final candidate waits for snapshot room.
  assign en          = !(is_cand && s4_ctl.fin && full);
  assign in_ch.ready = en;

  tnps_dist #(
    .IDX_W  (INDEX_BITS),
    .CRD_W  (COORD_BITS),
    .DIST_W (DIST_W)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_ch.valid),
    .in_cmd  (in_ch.cmd),
    .in_idx  (in_ch.vertex_index),
    .in_x    (in_ch.coord_x),
    .in_y    (in_ch.coord_y),
    .in_z    (in_ch.coord_z),
    .in_fin  (in_ch.final_candidate),
    .s4_ctl  (s4_ctl),
    .s4_idx  (s4_idx),
    .s4_dist (s4_dist)
  );

  assign dup            = |c_hit;
  assign cell_ctl.clear = en && is_query;
  assign cell_ctl.write = en && is_cand && !dup;
  assign cap            = en && is_cand && s4_ctl.fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_id_r <= '0;
    end else if (cell_ctl.clear) begin
      query_id_r <= s4_idx;
    end
  end

  generate
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign p_take[i] = 1'b0;
        assign p_dist[i] = '1;
        assign p_id[i]   = '0;
        assign p_vld[i]  = 1'b0;
      end else begin : g_link
        assign p_take[i] = c_take[i-1];
        assign p_dist[i] = c_dist[i-1];
        assign p_id[i]   = c_id[i-1];
        assign p_vld[i]  = c_vld[i-1];
      end

      tnps_cell #(
        .IDX_W  (INDEX_BITS),
        .DIST_W (DIST_W)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cell_ctl),
        .new_dist  (s4_dist),
        .new_id    (s4_idx),
        .prev_take (p_take[i]),
        .prev_dist (p_dist[i]),
        .prev_id   (p_id[i]),
        .prev_vld  (p_vld[i]),
        .take      (c_take[i]),
        .hit       (c_hit[i]),
        .cur_dist  (c_dist[i]),
        .id        (c_id[i]),
        .vld       (c_vld[i]),
        .id_nxt    (c_id_nxt[i]),
        .vld_nxt   (c_vld_nxt[i])
      );
    end
  endgenerate

  tnps_emit #(
    .IDX_W (INDEX_BITS)
  ) u_emit (
    .clk     (clk),
    .rst_n   (rst_n),
    .cap     (cap),
    .cap_qid (query_id_r),
    .cap_id  (c_id_nxt),
    .cap_vld (c_vld_nxt),
    .full    (full),
    .out_ch  (out_ch)
  );

  // Filled slots always form a prefix of the row.
  `TNPS_ALWAYS(a_slots_prefix, !(c_vld[1] && !c_vld[0]) && !(c_vld[2] && !c_vld[1]))
  // Filled slots stay in ascending distance order.
  `TNPS_ALWAYS(a_slots_sorted, (!c_vld[1] || (c_dist[0] <= c_dist[1])) &&
    (!c_vld[2] || (c_dist[1] <= c_dist[2])))
  // A query empties the whole list.
  `TNPS_NEXT(a_query_clears, cell_ctl.clear, c_vld == '0)
  // After a candidate is written, the nearest-rank slot is always filled.
  `TNPS_NEXT(a_write_fills, cell_ctl.write, c_vld[0])

endmodule

FILE: rtl/tnps_dist.sv
// Squared-distance pipeline: input register, differences, squares, sum.
module tnps_dist #(
  parameter int IDX_W  = tnps_pkg::INDEX_BITS_DEF,
  parameter int CRD_W  = tnps_pkg::COORD_BITS_DEF,
  parameter int DIST_W = tnps_pkg::dist_width(tnps_pkg::COORD_BITS_DEF)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  tnps_pkg::cmd_t          in_cmd,
  input  logic [IDX_W-1:0]        in_idx,
  input  logic signed [CRD_W-1:0] in_x,
  input  logic signed [CRD_W-1:0] in_y,
  input  logic signed [CRD_W-1:0] in_z,
  input  logic                    in_fin,
  output tnps_pkg::item_ctl_t     s4_ctl,
  output logic [IDX_W-1:0]        s4_idx,
  output logic [DIST_W-1:0]       s4_dist
);

  localparam int MAG_W = CRD_W + 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 2;

  tnps_pkg::item_ctl_t s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r;
  logic [IDX_W-1:0]    s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r;

  logic signed [CRD_W-1:0] s1_c_r [3];
  logic signed [CRD_W-1:0] query_r [3];
  logic signed [MAG_W-1:0] diff [3];
  logic [MAG_W-1:0]        mag [3];
  logic [MAG_W-1:0]        s2_mag_r [3];
  logic [SQ_W-1:0]         s3_sq_r [3];
  logic [SUM_W-1:0]        sum;
  logic [DIST_W-1:0]       dist_nxt;
  logic [DIST_W-1:0]       s4_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
    end else if (en) begin
      s1_ctl_r <= '{vld: in_vld, cmd: in_cmd, fin: in_fin};
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
      s4_ctl_r <= s3_ctl_r;
    end
  end

  // The query point changes as its request leaves the first stage, so the
  // candidate right behind it already measures against the new point.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        query_r[k] <= '0;
      end
    end else if (en && s1_ctl_r.vld && (s1_ctl_r.cmd == tnps_pkg::CMD_QUERY)) begin
      for (int k = 0; k < 3; k++) begin
        query_r[k] <= s1_c_r[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = MAG_W'(s1_c_r[k]) - MAG_W'(query_r[k]);
      mag[k]  = diff[k][MAG_W-1] ? $unsigned(-diff[k]) : $unsigned(diff[k]);
    end
  end

  always_comb begin
    sum = SUM_W'(s3_sq_r[0]) + SUM_W'(s3_sq_r[1]) + SUM_W'(s3_sq_r[2]);
  end

  generate
    if (SUM_W > DIST_W) begin : g_sat
      assign dist_nxt = (|sum[SUM_W-1:DIST_W]) ? '1 : sum[DIST_W-1:0];
    end else begin : g_exact
      assign dist_nxt = sum[DIST_W-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      s1_idx_r  <= in_idx;
      s1_c_r[0] <= in_x;
      s1_c_r[1] <= in_y;
      s1_c_r[2] <= in_z;
      s2_idx_r  <= s1_idx_r;
      s3_idx_r  <= s2_idx_r;
      s4_idx_r  <= s3_idx_r;
      for (int k = 0; k < 3; k++) begin
        s2_mag_r[k] <= mag[k];
        s3_sq_r[k]  <= SQ_W'(s2_mag_r[k]) * SQ_W'(s2_mag_r[k]);
      end
      s4_dist_r <= dist_nxt;
    end
  end

  assign s4_ctl  = s4_ctl_r;
  assign s4_idx  = s4_idx_r;
  assign s4_dist = s4_dist_r;

endmodule

FILE: rtl/tnps_cell.sv
// One ranked slot of the sorted nearest list; hands its entry to the next slot.
module tnps_cell #(
  parameter int IDX_W  = tnps_pkg::INDEX_BITS_DEF,
  parameter int DIST_W = tnps_pkg::dist_width(tnps_pkg::COORD_BITS_DEF)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tnps_pkg::cell_ctl_t ctl,
  input  logic [DIST_W-1:0]   new_dist,
  input  logic [IDX_W-1:0]    new_id,
  input  logic                prev_take,
  input  logic [DIST_W-1:0]   prev_dist,
  input  logic [IDX_W-1:0]    prev_id,
  input  logic                prev_vld,
  output logic                take,
  output logic                hit,
  output logic [DIST_W-1:0]   cur_dist,
  output logic [IDX_W-1:0]    id,
  output logic                vld,
  output logic [IDX_W-1:0]    id_nxt,
  output logic                vld_nxt
);

  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [IDX_W-1:0]  id_r, id_nxt_w;
  logic              vld_r, vld_nxt_w;

  // The list is sorted with empty slots at the tail, so the take flags run
  // monotonically down the row and the first one marks the insert point.
  assign take = !vld_r || (new_dist <= dist_r);
  assign hit  = vld_r && (id_r == new_id);

  always_comb begin
    dist_nxt  = dist_r;
    id_nxt_w  = id_r;
    vld_nxt_w = vld_r;
    if (ctl.clear) begin
      dist_nxt  = '1;
      id_nxt_w  = '0;
      vld_nxt_w = 1'b0;
    end else if (ctl.write) begin
      if (prev_take) begin
        dist_nxt  = prev_dist;
        id_nxt_w  = prev_id;
        vld_nxt_w = prev_vld;
      end else if (take) begin
        dist_nxt  = new_dist;
        id_nxt_w  = new_id;
        vld_nxt_w = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= '1;
      id_r   <= '0;
      vld_r  <= 1'b0;
    end else begin
      dist_r <= dist_nxt;
      id_r   <= id_nxt_w;
      vld_r  <= vld_nxt_w;
    end
  end

  assign cur_dist = dist_r;
  assign id       = id_r;
  assign vld      = vld_r;
  assign id_nxt   = id_nxt_w;
  assign vld_nxt  = vld_nxt_w;

endmodule

FILE: rtl/tnps_emit.sv
// Result buffer: holds list snapshots and sends them out one rank per transfer.
module tnps_emit #(
  parameter int IDX_W = tnps_pkg::INDEX_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cap,
  input  logic [IDX_W-1:0]                      cap_qid,
  input  logic [tnps_pkg::SLOTS-1:0][IDX_W-1:0] cap_id,
  input  logic [tnps_pkg::SLOTS-1:0]            cap_vld,
  output logic                                  full,
  tnps_out_if.source                            out_ch
);

  localparam int DEPTH = tnps_pkg::SNAP_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0]                      snap_qid_r [DEPTH];
  logic [tnps_pkg::SLOTS-1:0][IDX_W-1:0] snap_id_r  [DEPTH];
  logic [tnps_pkg::SLOTS-1:0]            snap_vld_r [DEPTH];

  logic [PTR_W-1:0]            wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [tnps_pkg::RANK_W-1:0] rank_r, rank_nxt;
  logic                        pop;
  logic                        last;

  assign last = (rank_r == tnps_pkg::LAST_RANK);
  assign pop  = out_ch.valid && out_ch.ready && last;
  assign full = (cnt_r == CNT_W'(DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    rank_nxt   = rank_r;
    cnt_nxt    = cnt_r;
    if (cap) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (out_ch.valid && out_ch.ready) begin
      rank_nxt = last ? tnps_pkg::FIRST_RANK : rank_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({cap, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      rank_r   <= tnps_pkg::FIRST_RANK;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      rank_r   <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      snap_qid_r[wr_ptr_r] <= cap_qid;
      snap_id_r[wr_ptr_r]  <= cap_id;
      snap_vld_r[wr_ptr_r] <= cap_vld;
    end
  end

  always_comb begin
    out_ch.valid           = (cnt_r != '0);
    out_ch.query_vertex    = snap_qid_r[rd_ptr_r];
    out_ch.rank            = rank_r;
    out_ch.found           = snap_vld_r[rd_ptr_r][rank_r];
    out_ch.neighbor_vertex = snap_vld_r[rd_ptr_r][rank_r] ? snap_id_r[rd_ptr_r][rank_r] : '0;
    out_ch.run_end         = last;
  end

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the three-nearest-point search block.
module tb;

  localparam int SLOTS       = tnps_pkg::SLOTS;
  localparam int RANK_W      = tnps_pkg::RANK_W;
  localparam int ITEM_TARGET = 450;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;
  localparam logic signed [15:0] CMAX = 16'sh7FFF;
  localparam logic signed [15:0] CMIN = 16'sh8000;

  typedef struct {
    tnps_pkg::cmd_t     cmd;
    logic [15:0]        vertex;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               final_mark;
  } request_t;

  typedef struct {
    logic [15:0]       query_vertex;
    logic [RANK_W-1:0] rank;
    logic [15:0]       neighbor;
    logic              found;
    logic              run_end;
  } ranking_t;

  // Keeps its own copy of the query point and ranked list, and the rankings still owed.
  class nearest_scoreboard;
    logic signed [15:0] query_xyz[3];
    logic [15:0]        query_id;
    longint             slot_dist[SLOTS];
    logic [15:0]        slot_id[SLOTS];
    bit                 slot_full[SLOTS];
    ranking_t           owed[$];
    int                 errors;

    function new();
      errors = 0;
      query_id = '0;
      foreach (query_xyz[i]) query_xyz[i] = '0;
      empty_list();
    endfunction

    function void empty_list();
      foreach (slot_full[i]) begin
        slot_dist[i] = -1;
        slot_id[i] = '0;
        slot_full[i] = 1'b0;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void note_request(request_t r);
      bit held;
      int pos;
      longint dx, dy, dz, sq_dist;
      ranking_t res;
      if (r.cmd == tnps_pkg::CMD_QUERY) begin
        query_xyz[0] = r.x;
        query_xyz[1] = r.y;
        query_xyz[2] = r.z;
        query_id = r.vertex;
        empty_list();
        return;
      end
      held = 1'b0;
      for (int i = 0; i < SLOTS; i++)
        if (slot_full[i] && slot_id[i] == r.vertex) held = 1'b1;
      if (!held) begin
        dx = longint'(r.x) - longint'(query_xyz[0]);
        dy = longint'(r.y) - longint'(query_xyz[1]);
        dz = longint'(r.z) - longint'(query_xyz[2]);
        sq_dist = dx * dx + dy * dy + dz * dz;
        pos = SLOTS;
        for (int i = 0; i < SLOTS && pos == SLOTS; i++)
          if (!slot_full[i] || sq_dist <= slot_dist[i]) pos = i;
        if (pos < SLOTS) begin
          for (int k = SLOTS - 1; k > pos; k--) begin
            slot_dist[k] = slot_dist[k-1];
            slot_id[k] = slot_id[k-1];
            slot_full[k] = slot_full[k-1];
          end
          slot_dist[pos] = sq_dist;
          slot_id[pos] = r.vertex;
          slot_full[pos] = 1'b1;
        end
      end
      if (r.final_mark) begin
        for (int k = 0; k < SLOTS; k++) begin
          res.query_vertex = query_id;
          res.rank = k[RANK_W-1:0];
          res.neighbor = slot_full[k] ? slot_id[k] : 16'd0;
          res.found = slot_full[k];
          res.run_end = (k == SLOTS - 1);
          owed = {owed, res};
        end
      end
    endfunction

    function bit field_ok(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: mismatch on %s, expected %0h, got %0h", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(ranking_t got);
      ranking_t want;
      bit ok;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, got query %0h rank %0d neighbour %0h found %0b end %0b",
                 $time, got.query_vertex, got.rank, got.neighbor, got.found, got.run_end);
        errors++;
        return;
      end
      want = owed.pop_front();
      ok = field_ok("query_vertex", want.query_vertex, got.query_vertex);
      ok &= field_ok("rank", 16'(want.rank), 16'(got.rank));
      ok &= field_ok("neighbor_vertex", want.neighbor, got.neighbor);
      ok &= field_ok("found", 16'(want.found), 16'(got.found));
      ok &= field_ok("run_end", 16'(want.run_end), 16'(got.run_end));
      if (!ok) errors++;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  tnps_in_if  in_ch ();
  tnps_out_if out_ch ();

  three_nearest_point_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  nearest_scoreboard sb = new();

  bit source_steady = 1'b0;
  bit sink_steady   = 1'b0;
  bit hold_results  = 1'b0;
  int sent_count    = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Mostly back-to-back, sometimes a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [15:0] near(input logic signed [15:0] c);
    logic signed [15:0] off;
    off = 16'($urandom_range(0, 6));
    return c + off - 16'sd3;
  endfunction

  // Called at a falling edge; returns at a falling edge after the request is taken and any random gap.
  task automatic offer(input tnps_pkg::cmd_t cmd, input logic [15:0] vertex,
                       input logic signed [15:0] x, input logic signed [15:0] y,
                       input logic signed [15:0] z, input logic final_mark);
    request_t r;
    int gap;
    r.cmd = cmd;
    r.vertex = vertex;
    r.x = x;
    r.y = y;
    r.z = z;
    r.final_mark = final_mark;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.vertex_index <= vertex;
    in_ch.coord_x <= x;
    in_ch.coord_y <= y;
    in_ch.coord_z <= z;
    in_ch.final_candidate <= final_mark;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(r);
    sent_count++;
    @(negedge clk);
    gap = source_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // A query (now and then left out) followed by a run of candidates, most of them close to the query point
  // and drawn from a small pool of indices so that ties and repeats are common.
  task automatic random_query_set();
    logic [15:0] qid, base, idx;
    logic signed [15:0] qx, qy, qz, cx, cy, cz;
    int n;
    source_steady = ($urandom_range(0, 4) == 0);
    qid = 16'($urandom());
    qx = 16'($urandom());
    qy = 16'($urandom());
    qz = 16'($urandom());
    base = 16'($urandom());
    if ($urandom_range(0, 6) != 0)
      offer(tnps_pkg::CMD_QUERY, qid, qx, qy, qz, 1'($urandom_range(0, 1)));
    else begin
      qx = sb.query_xyz[0];
      qy = sb.query_xyz[1];
      qz = sb.query_xyz[2];
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        // Stray request of any kind.
        offer(tnps_pkg::cmd_t'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()),
              16'($urandom()), 16'($urandom()), 1'($urandom_range(0, 1)));
        continue;
      end
      idx = ($urandom_range(0, 9) < 7) ? base + 16'($urandom_range(0, 7)) : 16'($urandom());
      if ($urandom_range(0, 9) < 6) begin
        cx = near(qx);
        cy = near(qy);
        cz = near(qz);
      end else begin
        cx = 16'($urandom());
        cy = 16'($urandom());
        cz = 16'($urandom());
      end
      offer(tnps_pkg::CMD_CAND, idx, cx, cy, cz, i == n - 1);
    end
  endtask

  // Result receiver: random stalls, calm stretches, and one long hold-off on request.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 59) == 0) sink_steady = !sink_steady;
      stall = sink_steady ? 0 : pick_gap();
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    ranking_t got;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.query_vertex = out_ch.query_vertex;
      got.rank = out_ch.rank;
      got.neighbor = out_ch.neighbor_vertex;
      got.found = out_ch.found;
      got.run_end = out_ch.run_end;
      sb.check_result(got);
    end
  end

  initial begin
    int waited;
    bit pressure_done;
    pressure_done = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= tnps_pkg::CMD_QUERY;
    in_ch.vertex_index <= '0;
    in_ch.coord_x <= '0;
    in_ch.coord_y <= '0;
    in_ch.coord_z <= '0;
    in_ch.final_candidate <= 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A final candidate straight out of reset ranks against the zero query point.
    offer(tnps_pkg::CMD_CAND, 16'd7, 16'sd1, 16'sd2, 16'sd2, 1'b1);
    // The final mark on a query is ignored.
    offer(tnps_pkg::CMD_QUERY, 16'hFFFF, CMIN, CMIN, CMIN, 1'b1);
    offer(tnps_pkg::CMD_CAND, 16'h0000, CMAX, CMAX, CMAX, 1'b0);
    offer(tnps_pkg::CMD_CAND, 16'hFFFF, CMIN, CMIN, CMIN, 1'b0);
    // A repeated index is dropped even when nearer, but its final mark still counts.
    offer(tnps_pkg::CMD_CAND, 16'h0000, CMIN, CMIN, CMIN, 1'b1);
    // Equal distances: the later candidate takes the better rank.
    offer(tnps_pkg::CMD_CAND, 16'd100, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    offer(tnps_pkg::CMD_CAND, 16'd101, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    offer(tnps_pkg::CMD_CAND, 16'd102, CMIN, CMIN, CMIN + 16'sd1, 1'b1);
    // The list carries on after its results have gone out.
    offer(tnps_pkg::CMD_CAND, 16'd103, CMIN, CMIN, CMIN, 1'b1);
    // Back-to-back queries, then a single candidate leaves two slots empty.
    offer(tnps_pkg::CMD_QUERY, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    offer(tnps_pkg::CMD_QUERY, 16'h1234, CMAX, 16'sd0, CMIN, 1'b0);
    offer(tnps_pkg::CMD_CAND, 16'h8000, CMIN, 16'sd0, CMAX, 1'b1);
    offer(tnps_pkg::CMD_CAND, 16'h0001, CMAX, 16'sd0, CMIN, 1'b1);
    offer(tnps_pkg::CMD_CAND, 16'h0002, CMAX - 16'sd5, 16'sd3, CMIN, 1'b0);
    // A full list drops a candidate that is further than all three.
    offer(tnps_pkg::CMD_CAND, 16'h0003, CMIN, CMIN, CMAX, 1'b1);
    offer(tnps_pkg::CMD_CAND, 16'h5555, 16'h5555, 16'hAAAA, 16'h5555, 1'b1);
    offer(tnps_pkg::CMD_CAND, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
    wait_for_results();

    while (sent_count < ITEM_TARGET) begin
      if (!pressure_done && sent_count >= 200) begin
        // Receiver holds off while final candidates pour in, so the block must stall.
        hold_results = 1'b1;
        source_steady = 1'b1;
        offer(tnps_pkg::CMD_QUERY, 16'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom()), 1'b0);
        repeat (12)
          offer(tnps_pkg::CMD_CAND, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                16'($urandom()), 1'b1);
        source_steady = 1'b0;
        wait_for_results();
        pressure_done = 1'b1;
      end
      random_query_set();
    end

    in_ch.valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
